[rtl/core/bmc_pkg.sv]
// ----------------------------------------------------------------------------
// bmc_pkg
// Shared types and constants of the Mohr-Coulomb bond failure pipeline.
// ----------------------------------------------------------------------------
package bmc_pkg;

  localparam int STRESS_BITS_DEF = 32;
  localparam int SUM_W  = 34;
  localparam int F4_W   = 35;
  localparam int MAG_W  = 35;
  localparam int RAD_W  = 72;
  localparam int ROOT_W = 36;
  localparam int REM_W  = 40;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_COS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TENSILE = 3'd4;

  localparam logic [1:0] OUT_KEPT    = 2'd0;
  localparam logic [1:0] OUT_SKIPPED = 2'd1;
  localparam logic [1:0] OUT_SHEAR   = 2'd2;
  localparam logic [1:0] OUT_TENSILE = 2'd3;

  typedef struct packed {
    logic signed [31:0] first_xx;
    logic signed [31:0] first_yy;
    logic signed [31:0] first_xy;
    logic signed [31:0] second_xx;
    logic signed [31:0] second_yy;
    logic signed [31:0] second_xy;
    logic               first_locked;
    logic               second_locked;
    logic               bond_live;
  } in_t;

  typedef struct packed {
    logic               bond_live_after;
    logic [1:0]         outcome;
    logic [31:0]        plane_shear;
    logic signed [31:0] plane_normal;
  } out_t;

  typedef struct packed {
    logic signed [15:0] cos_term;
    logic signed [15:0] sin_term;
    logic [15:0]        friction_slope;
    logic signed [31:0] cohesion;
    logic signed [31:0] tensile_strength;
  } cfg_t;

  typedef struct packed {
    logic signed [F4_W-1:0] f4;
    logic                   skip;
    logic                   live;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
    side_t             side;
  } sq_t;

endpackage

[rtl/core/bmc_front.sv]
// ----------------------------------------------------------------------------
// bmc_front
// Sums the end point stresses, forms the circle terms and the radicand.
// ----------------------------------------------------------------------------
module bmc_front #(
  parameter int STRESS_BITS = bmc_pkg::STRESS_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  bmc_pkg::in_t  in_data,
  output logic          out_valid,
  output bmc_pkg::sq_t  out_data
);

  localparam int RB = (STRESS_BITS <= 32) ? STRESS_BITS : 32;
  localparam int SW = bmc_pkg::SUM_W;
  localparam int FW = bmc_pkg::F4_W;
  localparam int MW = bmc_pkg::MAG_W;
  localparam int HW = MW - 18;

  logic signed [SW-1:0] ax, ay, axy, bx, by, bxy;

  if (STRESS_BITS <= 32) begin : g_sext
    assign ax  = {{(SW-RB){in_data.first_xx[RB-1]}},  in_data.first_xx[RB-1:0]};
    assign ay  = {{(SW-RB){in_data.first_yy[RB-1]}},  in_data.first_yy[RB-1:0]};
    assign axy = {{(SW-RB){in_data.first_xy[RB-1]}},  in_data.first_xy[RB-1:0]};
    assign bx  = {{(SW-RB){in_data.second_xx[RB-1]}}, in_data.second_xx[RB-1:0]};
    assign by  = {{(SW-RB){in_data.second_yy[RB-1]}}, in_data.second_yy[RB-1:0]};
    assign bxy = {{(SW-RB){in_data.second_xy[RB-1]}}, in_data.second_xy[RB-1:0]};
  end else begin : g_zext
    assign ax  = {2'b00, in_data.first_xx};
    assign ay  = {2'b00, in_data.first_yy};
    assign axy = {2'b00, in_data.first_xy};
    assign bx  = {2'b00, in_data.second_xx};
    assign by  = {2'b00, in_data.second_yy};
    assign bxy = {2'b00, in_data.second_xy};
  end

  logic v1_r, v2_r, v3_r, v4_r;
  logic signed [SW-1:0] sxx_r, syy_r, sxy_r;
  logic skip1_r, live1_r, skip2_r, live2_r, skip3_r, live3_r;
  logic signed [FW-1:0] f4_2_r, f4_3_r;
  logic [MW-1:0] md_r, me_r;
  logic [2*HW-1:0] dhh_r, ehh_r;
  logic [HW+18:0]  dhl_r, ehl_r;
  logic [35:0]     dll_r, ell_r;
  bmc_pkg::sq_t    sq_r;

  logic signed [FW-1:0] f4_nxt, d_nxt, e_nxt;
  logic [MW-1:0] md_nxt, me_nxt;
  logic [bmc_pkg::RAD_W-1:0] rad_nxt;

  always_comb begin
    f4_nxt = FW'(sxx_r) + FW'(syy_r);
    d_nxt  = FW'(sxx_r) - FW'(syy_r);
    e_nxt  = FW'(sxy_r) <<< 1;
    md_nxt = d_nxt[FW-1] ? MW'(-d_nxt) : MW'(d_nxt);
    me_nxt = e_nxt[FW-1] ? MW'(-e_nxt) : MW'(e_nxt);
    rad_nxt = (bmc_pkg::RAD_W'(dhh_r) << 36) + (bmc_pkg::RAD_W'(dhl_r) << 19)
            + bmc_pkg::RAD_W'(dll_r)
            + (bmc_pkg::RAD_W'(ehh_r) << 36) + (bmc_pkg::RAD_W'(ehl_r) << 19)
            + bmc_pkg::RAD_W'(ell_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sxx_r   <= ax + bx;
      syy_r   <= ay + by;
      sxy_r   <= axy + bxy;
      skip1_r <= in_data.first_locked | in_data.second_locked | ~in_data.bond_live;
      live1_r <= in_data.bond_live;
      f4_2_r  <= f4_nxt;
      md_r    <= md_nxt;
      me_r    <= me_nxt;
      skip2_r <= skip1_r;
      live2_r <= live1_r;
      dhh_r   <= md_r[MW-1:18] * md_r[MW-1:18];
      dhl_r   <= md_r[MW-1:18] * md_r[17:0];
      dll_r   <= md_r[17:0] * md_r[17:0];
      ehh_r   <= me_r[MW-1:18] * me_r[MW-1:18];
      ehl_r   <= me_r[MW-1:18] * me_r[17:0];
      ell_r   <= me_r[17:0] * me_r[17:0];
      f4_3_r  <= f4_2_r;
      skip3_r <= skip2_r;
      live3_r <= live2_r;
      sq_r.rem       <= '0;
      sq_r.root      <= '0;
      sq_r.rad       <= rad_nxt;
      sq_r.side.f4   <= f4_3_r;
      sq_r.side.skip <= skip3_r;
      sq_r.side.live <= live3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = sq_r;

endmodule

[rtl/core/bmc_sqrt_step.sv]
// ----------------------------------------------------------------------------
// bmc_sqrt_step
// One registered digit step of the integer square root.
// ----------------------------------------------------------------------------
module bmc_sqrt_step (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_valid,
  input  bmc_pkg::sq_t in_data,
  output logic         out_valid,
  output bmc_pkg::sq_t out_data
);

  localparam int RW = bmc_pkg::REM_W;
  localparam int QW = bmc_pkg::ROOT_W;
  localparam int NW = bmc_pkg::RAD_W;

  logic         v_r;
  bmc_pkg::sq_t d_r;
  bmc_pkg::sq_t d_nxt;
  logic [RW-1:0] r2, trial;

  always_comb begin
    d_nxt = in_data;
    r2    = {in_data.rem[RW-3:0], in_data.rad[NW-1:NW-2]};
    trial = RW'({in_data.root, 2'b01});
    d_nxt.rad = {in_data.rad[NW-3:0], 2'b00};
    if (r2 >= trial) begin
      d_nxt.rem  = r2 - trial;
      d_nxt.root = {in_data.root[QW-2:0], 1'b1};
    end else begin
      d_nxt.rem  = r2;
      d_nxt.root = {in_data.root[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

[rtl/core/bmc_back.sv]
// ----------------------------------------------------------------------------
// bmc_back
// Projects onto the failure plane, tests both criteria and saturates.
// ----------------------------------------------------------------------------
module bmc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  bmc_pkg::sq_t  in_data,
  input  bmc_pkg::cfg_t cfg,
  output logic          out_valid,
  output bmc_pkg::out_t out_data
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic skip1_r, live1_r, skip2_r, live2_r, skip3_r, live3_r;
  logic [51:0]        ps_r;
  logic signed [51:0] pc_r;
  logic signed [37:0] t4_r;
  logic signed [bmc_pkg::F4_W-1:0] f4_r;
  logic [35:0]        sh2_r, sh3_r;
  logic signed [35:0] nm2_r, nm3_r;
  logic               neg2_r, pos2_r, ten2_r, neg3_r, ten3_r;
  logic signed [53:0] sp_r;
  bmc_pkg::out_t      o_r;

  logic [15:0] sin_mag;
  logic signed [51:0] ns_nxt;
  logic signed [53:0] rhs;
  logic [53:0] rhs_mag;
  logic shear_hit;
  bmc_pkg::out_t o_nxt;

  always_comb begin
    sin_mag = cfg.sin_term[15] ? 16'(-cfg.sin_term) : 16'(cfg.sin_term);
    ns_nxt  = (52'(f4_r) <<< 14) - pc_r;
    rhs     = (54'(cfg.cohesion) <<< 10) - sp_r;
    rhs_mag = rhs[53] ? 54'(-rhs) : 54'(rhs);
    shear_hit = neg3_r && (54'({sh3_r, 10'b0}) >= rhs_mag);
    o_nxt.bond_live_after = 1'b0;
    o_nxt.outcome = bmc_pkg::OUT_KEPT;
    o_nxt.plane_shear = (|sh3_r[35:32]) ? 32'hFFFF_FFFF : sh3_r[31:0];
    if (nm3_r[35:31] == 5'b00000 || nm3_r[35:31] == 5'b11111) begin
      o_nxt.plane_normal = nm3_r[31:0];
    end else begin
      o_nxt.plane_normal = nm3_r[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    if (skip3_r) begin
      o_nxt.outcome = bmc_pkg::OUT_SKIPPED;
      o_nxt.bond_live_after = live3_r;
      o_nxt.plane_shear = '0;
      o_nxt.plane_normal = '0;
    end else if (shear_hit) begin
      o_nxt.outcome = bmc_pkg::OUT_SHEAR;
    end else if (ten3_r) begin
      o_nxt.outcome = bmc_pkg::OUT_TENSILE;
    end else begin
      o_nxt.bond_live_after = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ps_r    <= 52'(in_data.root) * 52'(sin_mag);
      pc_r    <= $signed({1'b0, in_data.root}) * cfg.cos_term;
      t4_r    <= 38'(in_data.side.f4) + 38'($signed({1'b0, in_data.root}));
      f4_r    <= in_data.side.f4;
      skip1_r <= in_data.side.skip;
      live1_r <= in_data.side.live;
      sh2_r   <= ps_r[51:16];
      nm2_r   <= ns_nxt[51:16];
      neg2_r  <= ns_nxt[51];
      pos2_r  <= ~ns_nxt[51] & (|ns_nxt);
      ten2_r  <= t4_r >= (38'(cfg.tensile_strength) <<< 2);
      skip2_r <= skip1_r;
      live2_r <= live1_r;
      sp_r    <= $signed({1'b0, cfg.friction_slope}) * nm2_r;
      sh3_r   <= sh2_r;
      nm3_r   <= nm2_r;
      neg3_r  <= neg2_r;
      ten3_r  <= ten2_r & pos2_r;
      skip3_r <= skip2_r;
      live3_r <= live2_r;
      o_r     <= o_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = o_r;

endmodule

[rtl/core/bond_mohr_coulomb_failure_top.sv]
// ----------------------------------------------------------------------------
// bond_mohr_coulomb_failure_top
// Mohr-Coulomb shear and tensile failure test of one 2D bond per beat.
// ----------------------------------------------------------------------------
// Usage:
//   One bond enters as one beat on in_valid/in_ready and leaves as one result
//   beat on out_valid/out_ready, in order. The five registers are written on
//   cfg_we with cfg_index and cfg_wdata; the user must do so only while no
//   bond is in flight, which the block does not enforce. There are four front
//   stages (sums, circle terms, partial squares, radicand), 36 square root
//   stages of one result bit each, and four back stages (projection, plane
//   stresses, friction product, tests). Throughput is one bond per cycle; the
//   pipeline moves as a whole with one bond per stage, and when the receiver
//   stalls a finished result, every stage holds and in_ready drops, so nothing
//   is lost. Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module bond_mohr_coulomb_failure_top #(
  parameter int STRESS_BITS = bmc_pkg::STRESS_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bmc_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bmc_pkg::out_t                    out_data,
  input  logic                             cfg_we,
  input  logic [bmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_wdata
);

  localparam int NSTEP = bmc_pkg::ROOT_W;

  bmc_pkg::cfg_t cfg_r;
  logic en;
  logic         sv [0:NSTEP];
  bmc_pkg::sq_t sd [0:NSTEP];

  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cos_term         <= 16'sd0;
      cfg_r.sin_term         <= 16'sd16384;
      cfg_r.friction_slope   <= 16'd0;
      cfg_r.cohesion         <= 32'sd0;
      cfg_r.tensile_strength <= 32'sd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bmc_pkg::REG_COS:     cfg_r.cos_term         <= cfg_wdata[15:0];
        bmc_pkg::REG_SIN:     cfg_r.sin_term         <= cfg_wdata[15:0];
        bmc_pkg::REG_SLOPE:   cfg_r.friction_slope   <= cfg_wdata[15:0];
        bmc_pkg::REG_COH:     cfg_r.cohesion         <= cfg_wdata;
        bmc_pkg::REG_TENSILE: cfg_r.tensile_strength <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bmc_front #(.STRESS_BITS(STRESS_BITS)) u_front (
    .clk, .rst_n, .en, .in_valid(in_valid & en), .in_data,
    .out_valid(sv[0]), .out_data(sd[0])
  );

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    bmc_sqrt_step u_step (
      .clk, .rst_n, .en,
      .in_valid(sv[i]), .in_data(sd[i]),
      .out_valid(sv[i+1]), .out_data(sd[i+1])
    );
  end

  bmc_back u_back (
    .clk, .rst_n, .en,
    .in_valid(sv[NSTEP]), .in_data(sd[NSTEP]), .cfg(cfg_r),
    .out_valid, .out_data
  );

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (~out_valid | out_ready))
    else $error("in_ready does not follow the pipeline enable");
  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outcome == bmc_pkg::OUT_SKIPPED |->
      out_data.plane_shear == '0 && out_data.plane_normal == '0)
    else $error("skipped bond carries nonzero plane stress");
  a_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.outcome == bmc_pkg::OUT_SHEAR ||
                  out_data.outcome == bmc_pkg::OUT_TENSILE) |->
      !out_data.bond_live_after)
    else $error("broken bond reported live");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

[dv/bond_mohr_coulomb_failure_top_tb.sv]
// ----------------------------------------------------------------------------
// bond_mohr_coulomb_failure_top_tb
// Self-checking bench for the Mohr-Coulomb bond failure pipeline: directed
// rows and random bonds with random gaps on both sides, checked in order
// against an exact integer predictor of the failure test.
// ----------------------------------------------------------------------------
module bond_mohr_coulomb_failure_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LAT = 44;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    bmc_pkg::in_t  bond;
    logic          chk;
    bmc_pkg::out_t res;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  bmc_pkg::in_t in_data;
  bmc_pkg::out_t out_data;
  logic cfg_we;
  logic [bmc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_wdata;

  bond_mohr_coulomb_failure_top i_dut (.*);

  logic signed [15:0] m_cos, m_sin;
  logic [15:0] m_slope;
  logic signed [31:0] m_coh, m_ten;

  bmc_pkg::out_t expected_results[$];
  int errors, accepted_bonds, checked_results, idle_cycles;
  int n_shear, n_tensile, n_kept, n_skip;
  bit done_sending;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic logic [71:0] root_floor(logic [71:0] n);
    logic [71:0] r, c;
    r = 0;
    for (int b = 35; b >= 0; b--) begin
      c = r | (72'd1 << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic bmc_pkg::out_t judge_bond(bmc_pkg::in_t b);
    bmc_pkg::out_t o;
    logic signed [127:0] sxx, syy, sxy, f4, d, e, r4, ns, nrm, shr, lhs, rhs;
    o = '0;
    if (b.first_locked || b.second_locked || !b.bond_live) begin
      o.bond_live_after = b.bond_live;
      o.outcome = bmc_pkg::OUT_SKIPPED;
      return o;
    end
    sxx = 128'(b.first_xx) + 128'(b.second_xx);
    syy = 128'(b.first_yy) + 128'(b.second_yy);
    sxy = 128'(b.first_xy) + 128'(b.second_xy);
    f4 = sxx + syy;
    d = sxx - syy;
    e = 2 * sxy;
    r4 = 128'(root_floor(72'(d * d + e * e)));
    shr = (r4 * (m_sin < 0 ? -128'(m_sin) : 128'(m_sin))) >>> 16;
    ns = f4 * 16384 - r4 * 128'(m_cos);
    nrm = ns >>> 16;
    lhs = shr * 1024;
    rhs = 128'(m_coh) * 1024 - 128'(m_slope) * nrm;
    if (rhs < 0) rhs = -rhs;
    if (ns < 0 && lhs >= rhs) o.outcome = bmc_pkg::OUT_SHEAR;
    else if (f4 + r4 >= 4 * 128'(m_ten) && ns > 0) o.outcome = bmc_pkg::OUT_TENSILE;
    else o.outcome = bmc_pkg::OUT_KEPT;
    o.bond_live_after = (o.outcome == bmc_pkg::OUT_KEPT);
    o.plane_shear = (shr > 128'h0FFFFFFFF) ? 32'hFFFFFFFF : shr[31:0];
    if (nrm > 128'sd2147483647) o.plane_normal = 32'h7FFFFFFF;
    else if (nrm < -128'sd2147483648) o.plane_normal = 32'h80000000;
    else o.plane_normal = nrm[31:0];
    return o;
  endfunction

  task automatic write_reg(logic [bmc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      bmc_pkg::REG_COS: m_cos = val[15:0];
      bmc_pkg::REG_SIN: m_sin = val[15:0];
      bmc_pkg::REG_SLOPE: m_slope = val[15:0];
      bmc_pkg::REG_COH: m_coh = val;
      bmc_pkg::REG_TENSILE: m_ten = val;
      default: ;
    endcase
  endtask

  task automatic drain_pipe();
    in_valid <= 0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 4) @(negedge clk);
  endtask

  task automatic send_bond(bmc_pkg::in_t b);
    int gap;
    gap = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(judge_bond(b));
    accepted_bonds++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_stress();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 2000) - 1000;
      3: return $urandom_range(0, 2000000) - 1000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic bmc_pkg::in_t rand_bond();
    bmc_pkg::in_t b;
    b.first_xx = rand_stress(); b.first_yy = rand_stress(); b.first_xy = rand_stress();
    b.second_xx = rand_stress(); b.second_yy = rand_stress(); b.second_xy = rand_stress();
    b.first_locked = ($urandom_range(0, 9) == 0);
    b.second_locked = ($urandom_range(0, 9) == 0);
    b.bond_live = ($urandom_range(0, 9) != 0);
    return b;
  endfunction

  function automatic bmc_pkg::in_t mk(logic [31:0] v, logic l1, logic l2, logic lv);
    bmc_pkg::in_t b;
    b = '{v, v, v, v, v, v, l1, l2, lv};
    return b;
  endfunction

  task automatic random_cfg(int k);
    case (k)
      0: begin
        write_reg(bmc_pkg::REG_COS, 16'hC000); write_reg(bmc_pkg::REG_SIN, 16'h4000);
        write_reg(bmc_pkg::REG_SLOPE, 16'd0); write_reg(bmc_pkg::REG_COH, 32'h7FFFFFFF);
        write_reg(bmc_pkg::REG_TENSILE, 32'h80000000);
      end
      1: begin
        write_reg(bmc_pkg::REG_COS, 16'h4000); write_reg(bmc_pkg::REG_SIN, 16'hC000);
        write_reg(bmc_pkg::REG_SLOPE, 16'hFFFF); write_reg(bmc_pkg::REG_COH, 32'h80000000);
        write_reg(bmc_pkg::REG_TENSILE, 32'h7FFFFFFF);
      end
      default: begin
        write_reg(bmc_pkg::REG_COS, $urandom_range(0, 32768) - 16384);
        write_reg(bmc_pkg::REG_SIN, $urandom);
        write_reg(bmc_pkg::REG_SLOPE, $urandom_range(0, 2048));
        write_reg(bmc_pkg::REG_COH, $urandom_range(0, 2000000) - 1000000);
        write_reg(bmc_pkg::REG_TENSILE, $urandom_range(0, 4000000) - 2000000);
      end
    endcase
  endtask

  // Result side: random stalls and in-order checking.
  initial begin
    out_ready = 0;
    forever begin
      int w;
      @(negedge clk);
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
      if (w != 0) begin
        out_ready <= 0;
        repeat (w) @(negedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        bmc_pkg::out_t x;
        x = expected_results.pop_front();
        checked_results++;
        case (x.outcome)
          bmc_pkg::OUT_SHEAR: n_shear++;
          bmc_pkg::OUT_TENSILE: n_tensile++;
          bmc_pkg::OUT_KEPT: n_kept++;
          default: n_skip++;
        endcase
        if (out_data.bond_live_after !== x.bond_live_after) begin
          $error("bond_live_after exp %0d got %0d", x.bond_live_after,
                 out_data.bond_live_after); errors++;
        end
        if (out_data.outcome !== x.outcome) begin
          $error("outcome exp %0d got %0d", x.outcome, out_data.outcome); errors++;
        end
        if (out_data.plane_shear !== x.plane_shear) begin
          $error("plane_shear exp %0d got %0d", x.plane_shear,
                 out_data.plane_shear); errors++;
        end
        if (out_data.plane_normal !== x.plane_normal) begin
          $error("plane_normal exp %0d got %0d", x.plane_normal,
                 out_data.plane_normal); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || done_sending)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    rst_n = 0; in_valid = 0; in_data = '0;
    cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
    errors = 0; accepted_bonds = 0; checked_results = 0; idle_cycles = 0;
    n_shear = 0; n_tensile = 0; n_kept = 0; n_skip = 0; done_sending = 0;
    m_cos = 0; m_sin = 16384; m_slope = 0; m_coh = 0; m_ten = 0;
    repeat (12) @(negedge clk);
    rst_n = 1;

    rows.push_back('{mk(32'd0, 0, 0, 1), 1, '{1'b1, bmc_pkg::OUT_KEPT, 32'd0, 32'sd0}});
    rows.push_back('{mk(32'd5, 1, 0, 1), 1, '{1'b1, bmc_pkg::OUT_SKIPPED, 32'd0, 32'sd0}});
    rows.push_back('{mk(32'd5, 0, 1, 1), 1, '{1'b1, bmc_pkg::OUT_SKIPPED, 32'd0, 32'sd0}});
    rows.push_back('{mk(32'd5, 0, 0, 0), 1, '{1'b0, bmc_pkg::OUT_SKIPPED, 32'd0, 32'sd0}});
    rows.push_back('{mk(32'd5, 1, 1, 0), 1, '{1'b0, bmc_pkg::OUT_SKIPPED, 32'd0, 32'sd0}});
    rows.push_back('{mk(32'h7FFFFFFF, 0, 0, 1), 0, '0});
    rows.push_back('{mk(32'h80000000, 0, 0, 1), 0, '0});
    rows.push_back('{mk(32'hFFFFFFFF, 0, 0, 1), 0, '0});
    rows.push_back('{mk(32'd1, 0, 0, 1), 0, '0});
    for (int i = 0; i < 8; i++) rows.push_back('{rand_bond(), 0, '0});

    foreach (rows[i]) begin
      send_bond(rows[i].bond);
      if (rows[i].chk) expected_results[$] = rows[i].res;
    end
    drain_pipe();

    // Out-of-range index must be ignored.
    write_reg(3'd7, 32'hFFFFFFFF);
    for (int k = 0; k < 2; k++) begin
      random_cfg(k);
      for (int i = 0; i < 5; i++) send_bond(mk(rand_stress(), 0, 0, 1));
      send_bond(rand_bond());
      drain_pipe();
    end

    for (int ph = 0; ph < 10; ph++) begin
      random_cfg(ph < 2 ? ph : 2);
      for (int i = 0; i < 82; i++) send_bond(rand_bond());
      drain_pipe();
    end

    done_sending = 1;
    $display("Bonds sent: %0d, checked: %0d (kept %0d, skipped %0d, shear %0d, tensile %0d)",
             accepted_bonds, checked_results, n_kept, n_skip, n_shear, n_tensile);
    $display("Covered locked ends, dead bonds, stress extremes and register extremes.");
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
